@@ design/brzc_pkg.sv @@
// Shared types and constants for the block RMS / zero-crossing tracker.
// No dependencies; used by brzc_root_div and the top level.
`timescale 1ns / 1ps

package brzc_pkg;

  // Q1.16 fixed-point constants
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 17;
  localparam logic [CFG_IW-1:0] CFG_SMOOTH_WEIGHT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LEVEL_GAIN    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_FREQ_GAIN     = 2'd2;

  localparam logic [16:0] SMOOTH_WEIGHT_RST = 17'd26214;
  localparam logic [4:0]  LEVEL_GAIN_RST    = 5'd5;
  localparam logic [4:0]  FREQ_GAIN_RST     = 5'd2;

  // operation of the shared root / divide unit
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

endpackage

@@ design/block_rms_zero_crossing_tracker.sv @@
// Top level of the block RMS level and zero-crossing-rate tracker.
// Uses brzc_pkg and brzc_root_div (shared divide / square-root unit).
`timescale 1ns / 1ps

// Usage:
//  Input channel (sample, block_end; in_valid / in_stall): one beat per
//  audio sample, block_end marks the last sample of a block. A beat is
//  taken when in_valid is high and in_stall low.
//  Output channel (level, frequency, overflowed; out_valid / out_stall):
//  one beat per block end. The result sits in an output register until
//  taken, and the block goes on accepting samples meanwhile.
//  Config channel (cfg_index, cfg_data; cfg_valid / cfg_ready): cfg_ready
//  is always high; write only while no block end is in progress.
//  Sequence: an ordinary sample is accepted, squared and then accumulated,
//  the square going through the one shared 17x17 multiplier; a dropped
//  one is only accepted. A block end then runs two divides and one root
//  in the bit-serial unit (unit width UW = 33+clog2(MAX_SAMPLES) rounded up
//  to even; 44 at the default), then smoothing and gain. If the output
//  register is still full, the block waits in its final step until the
//  receiver takes the old beat.
//  Reset: synchronous; clears accumulators and smoothed values and loads
//  the default weight and gains. No clearing pass is needed.

module block_rms_zero_crossing_tracker #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [15:0]          sample,
  input  logic                        block_end,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic [16:0]                 level,
  output logic [16:0]                 frequency,
  output logic                        overflowed,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brzc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [brzc_pkg::CFG_DW-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int XW  = $clog2(MAX_SAMPLES);
  localparam int SW  = 31 + $clog2(MAX_SAMPLES);
  localparam int UW0 = SW + 2;
  localparam int UW  = UW0 + (UW0 % 2);

  typedef enum logic [16:0] {
    S_IDLE          = 17'h00001,
    S_SQUARE        = 17'h00002,
    S_ACCUM         = 17'h00004,
    S_LVL_DIV       = 17'h00008,
    S_LVL_DIV_WAIT  = 17'h00010,
    S_LVL_ROOT      = 17'h00020,
    S_LVL_ROOT_WAIT = 17'h00040,
    S_RATE_DIV      = 17'h00080,
    S_RATE_DIV_WAIT = 17'h00100,
    S_SM_LVL_OLD    = 17'h00200,
    S_SM_LVL_NEW    = 17'h00400,
    S_SM_LVL_SUM    = 17'h00800,
    S_SM_RATE_NEW   = 17'h01000,
    S_SM_RATE_SUM   = 17'h02000,
    S_AMP_LVL       = 17'h04000,
    S_AMP_RATE      = 17'h08000,
    S_EMIT          = 17'h10000
  } state_t;

  state_t state;

  // configuration
  logic [16:0] smooth_weight;
  logic [4:0]  level_gain;
  logic [4:0]  freq_gain;

  // block accumulators
  logic [SW-1:0] square_sum;
  logic [CW-1:0] sample_count;
  logic [XW-1:0] crossing_count;
  logic          prev_pos;
  logic          drop_flag;
  logic          last_r;
  logic [15:0]   mag;

  // smoothing and output datapath
  logic [16:0] smoothed_level;
  logic [16:0] smoothed_rate;
  logic [16:0] raw_level;
  logic [16:0] raw_rate;
  logic [16:0] lvl_amp;
  logic [16:0] frq_amp;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] prod;
  logic [33:0] acc;
  logic [33:0] acc_sum;

  logic [16:0] w_eff;
  logic [16:0] w_inv;
  logic        pos;
  logic        count_zero;
  logic        out_free;

  brzc_pkg::unit_req_t unit_req;
  logic [UW-1:0]       unit_operand;
  logic                unit_done;
  logic [UW-1:0]       unit_result;
  logic [16:0]         unit_sat;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign pos        = !sample[15] && (sample != 16'sd0);
  assign count_zero = (sample_count == '0);
  assign out_free   = !out_valid || !out_stall;
  assign w_eff      = (smooth_weight > brzc_pkg::ONE_Q16) ? brzc_pkg::ONE_Q16 : smooth_weight;
  assign w_inv      = brzc_pkg::ONE_Q16 - w_eff;
  assign acc_sum    = acc + prod;
  assign unit_sat   = (unit_result > UW'(brzc_pkg::ONE_Q16)) ? brzc_pkg::ONE_Q16
                                                              : unit_result[16:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQUARE: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, mag};
      end
      S_SM_LVL_OLD: begin
        mul_a = smoothed_level;
        mul_b = w_inv;
      end
      S_SM_LVL_NEW: begin
        mul_a = raw_level;
        mul_b = w_eff;
      end
      S_SM_LVL_SUM: begin
        mul_a = smoothed_rate;
        mul_b = w_inv;
      end
      S_SM_RATE_NEW: begin
        mul_a = raw_rate;
        mul_b = w_eff;
      end
      S_SM_RATE_SUM: begin
        mul_a = smoothed_level;
        mul_b = 17'(level_gain);
      end
      S_AMP_LVL: begin
        mul_a = smoothed_rate;
        mul_b = 17'(freq_gain);
      end
      default: ;
    endcase
  end

  // requests to the root / divide unit
  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = brzc_pkg::OP_DIV;
    unit_operand   = UW'({square_sum, 2'b00});
    case (state)
      S_LVL_DIV: begin
        unit_req.start = 1'b1;
      end
      S_LVL_ROOT: begin
        unit_req.start = 1'b1;
        unit_req.op    = brzc_pkg::OP_SQRT;
        unit_operand   = unit_result;
      end
      S_RATE_DIV: begin
        unit_req.start = 1'b1;
        unit_operand   = UW'({crossing_count, 16'h0000});
      end
      default: ;
    endcase
  end

  brzc_root_div #(
    .UW(UW),
    .CW(CW)
  ) u_root_div (
    .clk     (clk),
    .rst     (rst),
    .req     (unit_req),
    .operand (unit_operand),
    .divisor (sample_count),
    .done    (unit_done),
    .result  (unit_result)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_weight <= brzc_pkg::SMOOTH_WEIGHT_RST;
      level_gain    <= brzc_pkg::LEVEL_GAIN_RST;
      freq_gain     <= brzc_pkg::FREQ_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        brzc_pkg::CFG_SMOOTH_WEIGHT: smooth_weight <= cfg_data;
        brzc_pkg::CFG_LEVEL_GAIN:    level_gain    <= cfg_data[4:0];
        brzc_pkg::CFG_FREQ_GAIN:     freq_gain     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      square_sum     <= '0;
      sample_count   <= '0;
      crossing_count <= '0;
      prev_pos       <= 1'b0;
      drop_flag      <= 1'b0;
      smoothed_level <= '0;
      smoothed_rate  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (sample_count < CW'(MAX_SAMPLES)) begin
              if (!count_zero && (pos != prev_pos)) begin
                crossing_count <= crossing_count + 1'b1;
              end
              prev_pos     <= pos;
              sample_count <= sample_count + 1'b1;
              state        <= S_SQUARE;
            end else begin
              // block full: drop, but still honor the block end
              drop_flag <= 1'b1;
              state     <= block_end ? S_LVL_DIV : S_IDLE;
            end
          end
        end
        S_SQUARE: state <= S_ACCUM;
        S_ACCUM: begin
          square_sum <= square_sum + SW'(prod);
          state      <= last_r ? S_LVL_DIV : S_IDLE;
        end
        S_LVL_DIV: state <= S_LVL_DIV_WAIT;
        S_LVL_DIV_WAIT: begin
          if (unit_done) begin
            state <= S_LVL_ROOT;
          end
        end
        S_LVL_ROOT: state <= S_LVL_ROOT_WAIT;
        S_LVL_ROOT_WAIT: begin
          if (unit_done) begin
            state <= S_RATE_DIV;
          end
        end
        S_RATE_DIV: state <= S_RATE_DIV_WAIT;
        S_RATE_DIV_WAIT: begin
          if (unit_done) begin
            state <= S_SM_LVL_OLD;
          end
        end
        S_SM_LVL_OLD:  state <= S_SM_LVL_NEW;
        S_SM_LVL_NEW:  state <= S_SM_LVL_SUM;
        S_SM_LVL_SUM: begin
          smoothed_level <= acc_sum[32:16];
          state          <= S_SM_RATE_NEW;
        end
        S_SM_RATE_NEW: state <= S_SM_RATE_SUM;
        S_SM_RATE_SUM: begin
          smoothed_rate <= acc_sum[32:16];
          state         <= S_AMP_LVL;
        end
        S_AMP_LVL:  state <= S_AMP_RATE;
        S_AMP_RATE: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            square_sum     <= '0;
            sample_count   <= '0;
            crossing_count <= '0;
            prev_pos       <= 1'b0;
            drop_flag      <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          last_r <= block_end;
          mag    <= sample[15] ? (~sample + 16'd1) : sample;
        end
      end
      S_LVL_ROOT_WAIT: begin
        if (unit_done) begin
          raw_level <= count_zero ? 17'd0 : unit_sat;
        end
      end
      S_RATE_DIV_WAIT: begin
        if (unit_done) begin
          raw_rate <= count_zero ? 17'd0 : unit_sat;
        end
      end
      S_SM_LVL_NEW:  acc <= prod + 34'(brzc_pkg::HALF_Q16);
      S_SM_RATE_NEW: acc <= prod + 34'(brzc_pkg::HALF_Q16);
      S_AMP_LVL: begin
        lvl_amp <= (prod > 34'(brzc_pkg::ONE_Q16)) ? brzc_pkg::ONE_Q16 : prod[16:0];
      end
      S_AMP_RATE: begin
        frq_amp <= (prod > 34'(brzc_pkg::ONE_Q16)) ? brzc_pkg::ONE_Q16 : prod[16:0];
      end
      S_EMIT: begin
        if (out_free) begin
          level      <= lvl_amp;
          frequency  <= frq_amp;
          overflowed <= drop_flag;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/brzc_root_div.sv @@
// Shared iterative unit: restoring divide (one quotient bit per cycle) or
// integer square root (one root bit per cycle). Uses brzc_pkg.
`timescale 1ns / 1ps

module brzc_root_div #(
  parameter int UW = 44,
  parameter int CW = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  brzc_pkg::unit_req_t req,
  input  logic [UW-1:0]      operand,
  input  logic [CW-1:0]      divisor,
  output logic               done,
  output logic [UW-1:0]      result
);

  localparam int HW = UW / 2;
  localparam int TW = (CW + 1 > HW + 3) ? CW + 1 : HW + 3;
  localparam int NW = $clog2(UW + 1);

  logic                busy;
  brzc_pkg::unit_op_t  op_r;
  logic [UW-1:0]       work;   // dividend out / quotient in, or radicand
  logic [TW-1:0]       rem;
  logic [HW-1:0]       root;
  logic [NW-1:0]       cnt;

  logic [TW-1:0] trial;
  logic [TW-1:0] sub;
  logic [TW:0]   diff;
  logic          ge;

  // one compare/subtract serves both operations
  always_comb begin
    if (op_r == brzc_pkg::OP_DIV) begin
      trial = {rem[TW-2:0], work[UW-1]};
      sub   = TW'(divisor);
    end else begin
      trial = {rem[TW-3:0], work[UW-1:UW-2]};
      sub   = TW'({root, 2'b01});
    end
    diff = {1'b0, trial} - {1'b0, sub};
    ge   = ~diff[TW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == NW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == brzc_pkg::OP_DIV) ? NW'(UW) : NW'(HW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      work <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem <= ge ? diff[TW-1:0] : trial;
      if (op_r == brzc_pkg::OP_DIV) begin
        work <= {work[UW-2:0], ge};
      end else begin
        work <= {work[UW-3:0], 2'b00};
        root <= {root[HW-2:0], ge};
      end
    end
  end

  assign result = (op_r == brzc_pkg::OP_DIV) ? work : UW'(root);

endmodule

@@ sim/tb_block_rms_zero_crossing_tracker.sv @@
// Self-checking testbench for block_rms_zero_crossing_tracker: a queue-fed driver, a monitor
// and a transaction-level predictor of the per-block RMS level and zero-crossing rate.
// Depends on brzc_pkg and the design sources under design/.
`timescale 1ns / 1ps

module tb_block_rms_zero_crossing_tracker;

  localparam int MAX_SMP = 2048;
  localparam logic [brzc_pkg::CFG_IW-1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int SETTLE_CYC = 300;
  localparam int WD_LIMIT = 20000;
  localparam int HOLD_CYC = 4000;

  typedef struct {
    logic signed [15:0] smp;
    logic               last;
  } sample_beat_t;

  typedef struct {
    logic [16:0] level;
    logic [16:0] freq;
    logic        ovf;
  } block_report_t;

  typedef enum int {
    PAT_FULL,
    PAT_QUIET,
    PAT_EDGE,
    PAT_SIGN
  } pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic signed [15:0] sample = '0;
  logic block_end = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [16:0] level;
  logic [16:0] frequency;
  logic overflowed;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brzc_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [brzc_pkg::CFG_DW-1:0] cfg_data = '0;

  block_rms_zero_crossing_tracker #(
    .MAX_SAMPLES(MAX_SMP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .block_end(block_end),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .level(level),
    .frequency(frequency),
    .overflowed(overflowed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [16:0] weight_q16;
  logic [4:0]  lvl_gain;
  logic [4:0]  rate_gain;
  longint unsigned sq_sum;
  int unsigned n_smp;
  int unsigned n_cross;
  int          prev_smp;
  longint unsigned lvl_smooth;
  longint unsigned rate_smooth;
  bit          dropped;

  sample_beat_t  sample_feed[$];
  block_report_t block_reports[$];
  sample_beat_t  on_wire;

  int  errors = 0;
  int  cfg_beats = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  rx_hold_left = 0;
  int  rx_stall_left = 0;
  int  tx_gap_left = 0;
  int  rx_gap;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(30, 90);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // exponential smoothing, rounds half up
  function automatic longint unsigned blend(input longint unsigned old_v,
                                            input longint unsigned raw_v,
                                            input longint unsigned w);
    return (old_v * (65536 - w) + raw_v * w + 32768) >> 16;
  endfunction

  function automatic logic [16:0] boost(input longint unsigned v, input logic [4:0] g);
    longint unsigned p;
    p = v * g;
    return (p > brzc_pkg::ONE_Q16) ? brzc_pkg::ONE_Q16 : p[16:0];
  endfunction

  task automatic tally_sample(input sample_beat_t b);
    int sv;
    longint unsigned mag, raw_lvl, raw_rate, w;
    block_report_t r;
    sv = b.smp;
    if (n_smp < MAX_SMP) begin
      mag = 64'((sv < 0) ? -sv : sv);
      sq_sum += mag * mag;
      if (n_smp > 0 && ((sv > 0) != (prev_smp > 0))) n_cross++;
      prev_smp = sv;
      n_smp++;
    end else begin
      dropped = 1'b1;
    end
    if (b.last) begin
      w = 64'((weight_q16 > brzc_pkg::ONE_Q16) ? brzc_pkg::ONE_Q16 : weight_q16);
      raw_lvl = 0;
      raw_rate = 0;
      if (n_smp > 0) begin
        raw_lvl = int_root((sq_sum * 4) / n_smp);
        raw_rate = (longint'(n_cross) << 16) / n_smp;
      end
      if (raw_lvl > brzc_pkg::ONE_Q16) raw_lvl = 64'(brzc_pkg::ONE_Q16);
      if (raw_rate > brzc_pkg::ONE_Q16) raw_rate = 64'(brzc_pkg::ONE_Q16);
      lvl_smooth = blend(lvl_smooth, raw_lvl, w);
      rate_smooth = blend(rate_smooth, raw_rate, w);
      r.level = boost(lvl_smooth, lvl_gain);
      r.freq = boost(rate_smooth, rate_gain);
      r.ovf = dropped;
      block_reports.push_back(r);
      sq_sum = 0;
      n_smp = 0;
      n_cross = 0;
      prev_smp = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  task automatic check_block_report();
    block_report_t e;
    if (block_reports.size() == 0) begin
      report_mismatch($sformatf("result beat with none pending: level %0d freq %0d ovf %0b",
                                level, frequency, overflowed));
    end else begin
      e = block_reports.pop_front();
      if (level !== e.level)
        report_mismatch($sformatf("level got %0d want %0d", level, e.level));
      if (frequency !== e.freq)
        report_mismatch($sformatf("frequency got %0d want %0d", frequency, e.freq));
      if (overflowed !== e.ovf)
        report_mismatch($sformatf("overflowed got %0b want %0b", overflowed, e.ovf));
    end
  endtask

  // driver: holds a stalled beat, else presents the next queued sample after a random gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap_left = 0;
      sq_sum = 0;
      n_smp = 0;
      n_cross = 0;
      prev_smp = 0;
      lvl_smooth = 0;
      rate_smooth = 0;
      dropped = 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) tally_sample(on_wire);
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (sample_feed.size() > 0) begin
        on_wire = sample_feed.pop_front();
        sample <= on_wire.smp;
        block_end <= on_wire.last;
        in_valid <= 1'b1;
        tx_gap_left = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // config writes land in the predictor at the handshake edge
  always @(posedge clk) begin
    if (rst) begin
      weight_q16 = brzc_pkg::SMOOTH_WEIGHT_RST;
      lvl_gain = brzc_pkg::LEVEL_GAIN_RST;
      rate_gain = brzc_pkg::FREQ_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        brzc_pkg::CFG_SMOOTH_WEIGHT: weight_q16 = cfg_data;
        brzc_pkg::CFG_LEVEL_GAIN:    lvl_gain = cfg_data[4:0];
        brzc_pkg::CFG_FREQ_GAIN:     rate_gain = cfg_data[4:0];
        default: ;
      endcase
      cfg_beats++;
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_stall_left = 0;
      rx_hold_left = 0;
    end else begin
      if (out_valid && !out_stall) check_block_report();
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_hold_left = HOLD_CYC;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        rx_gap = calm ? 0 : pick_gap();
        if (rx_gap > 0) begin
          rx_stall_left = rx_gap - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_sample(input pattern_t p);
    int m;
    case (p)
      PAT_QUIET: return 16'($urandom_range(0, 6) - 3);
      PAT_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh8001;
          3: return 16'sh0000;
          4: return 16'sh0001;
          default: return 16'shFFFF;
        endcase
      end
      PAT_SIGN: begin
        m = $urandom_range(1, 32767);
        return 16'($urandom_range(0, 1) ? -m : m);
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_beat(input logic signed [15:0] smp, input logic last);
    sample_beat_t b;
    b.smp = smp;
    b.last = last;
    sample_feed.push_back(b);
  endtask

  task automatic add_block(input int len, input pattern_t p, input bit mixed);
    for (int i = 0; i < len; i++)
      add_beat(rand_sample(mixed ? pattern_t'($urandom_range(0, 3)) : p), i == len - 1);
  endtask

  task automatic add_directed();
    add_beat(16'sh8000, 1'b1);           // full-scale negative, level hits 1.0
    add_beat(16'sh7FFF, 1'b1);
    add_beat(16'sh0000, 1'b1);           // silence
    add_beat(-16'sd5, 1'b1);
    // zero counts as non-positive: 0->1, 1->0 and -1->5 cross, 0->-1 does not
    add_beat(16'sh0000, 1'b0);
    add_beat(16'sh0001, 1'b0);
    add_beat(16'sh0000, 1'b0);
    add_beat(16'shFFFF, 1'b0);
    add_beat(16'sh0005, 1'b1);
    add_beat(16'sh7FFF, 1'b0);
    add_beat(16'sh8000, 1'b0);
    add_beat(16'sh7FFF, 1'b0);
    add_beat(16'sh8000, 1'b1);
    add_beat(16'sh0001, 1'b0);
    add_beat(16'sh0002, 1'b0);
    add_beat(16'sh0003, 1'b1);
  endtask

  task automatic add_random(input int n_items);
    int added, len, r;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 12);
      else if (r < 95) len = $urandom_range(13, 64);
      else len = $urandom_range(65, 400);
      if (len > n_items - added) len = n_items - added;
      add_block(len, pattern_t'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
      added += len;
    end
  endtask

  task automatic write_reg(input logic [brzc_pkg::CFG_IW-1:0] idx,
                           input logic [brzc_pkg::CFG_DW-1:0] val);
    int target;
    target = cfg_beats + 1;
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    wait (cfg_beats >= target);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [16:0] w, input logic [4:0] lg, input logic [4:0] fg);
    write_reg(brzc_pkg::CFG_SMOOTH_WEIGHT, w);
    write_reg(brzc_pkg::CFG_LEVEL_GAIN, {12'd0, lg});
    write_reg(brzc_pkg::CFG_FREQ_GAIN, {12'd0, fg});
  endtask

  task automatic drain();
    while (sample_feed.size() != 0 || in_valid || block_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults
    add_directed();
    drain();
    add_random(60);
    drain();

    // no smoothing, unity gain, no idling
    write_all(17'd65536, 5'd1, 5'd1);
    calm = 1'b1;
    add_directed();
    add_random(40);
    drain();
    calm = 1'b0;

    // weight 0 freezes the smoothed values; max in-range gains
    write_all(17'd0, 5'd16, 5'd16);
    add_random(30);
    drain();

    // weight above 1.0 is clamped; gains outside 1..16
    write_all(17'h1FFFF, 5'd0, 5'd31);
    write_reg(CFG_SPARE, 17'($urandom_range(0, 131071)));
    add_random(30);
    drain();

    write_all(17'd1, 5'd17, 5'd16);
    add_random(30);
    drain();

    repeat (3) begin
      write_all(17'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 65536)),
                5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      add_random(20);
      drain();
    end

    // receiver holds off while short blocks stream in back to back
    write_all(brzc_pkg::SMOOTH_WEIGHT_RST, 5'd3, 5'd4);
    calm = 1'b1;
    hold_req++;
    repeat (30) add_block($urandom_range(1, 4), PAT_FULL, 1'b0);
    drain();

    // over-length block: the first MAX_SMP beats count, the rest are dropped,
    // the block end rides on a dropped beat; then a short clean block
    write_all(17'd65536, 5'd1, 5'd1);
    for (int i = 0; i < MAX_SMP + 3; i++)
      add_beat((i % 2) ? 16'sh8000 : 16'sh7FFF, i == MAX_SMP + 2);
    add_beat(16'sh0001, 1'b1);
    drain();
    calm = 1'b0;

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
